[sv/xalu_pkg.sv]
// Package: operation codes, size codes and item types for the x86 ALU flags unit.
`default_nettype none

package xalu_pkg;

    localparam logic [3:0] CMD_ADC  = 4'd0;
    localparam logic [3:0] CMD_ADD  = 4'd1;
    localparam logic [3:0] CMD_AND  = 4'd2;
    localparam logic [3:0] CMD_CMP  = 4'd3;
    localparam logic [3:0] CMD_OR   = 4'd4;
    localparam logic [3:0] CMD_SBB  = 4'd5;
    localparam logic [3:0] CMD_SUB  = 4'd6;
    localparam logic [3:0] CMD_TEST = 4'd7;
    localparam logic [3:0] CMD_XOR  = 4'd8;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;

    typedef struct packed {
        logic [3:0]  command;
        logic [1:0]  operand_size;
        logic [31:0] dest_value;
        logic [31:0] source_value;
        logic        sign_extend_byte;
        logic        carry_in;
    } xalu_op_t;

    typedef struct packed {
        logic [31:0] result;
        logic        write_back;
        logic        carry_flag;
        logic        parity_flag;
        logic        aux_carry_flag;
        logic        zero_flag;
        logic        sign_flag;
        logic        overflow_flag;
    } xalu_res_t;

endpackage

`default_nettype wire

[sv/x86_integer_alu_flags_unit.sv]
// Top level: input register, ALU datapath and result register with valid/ready handshakes.
// Each item moves from the input register to the result register, which drives the output.
// Throughput: one item per cycle while out_ready holds; the two registers advance together.
// A stalled output holds the result register; the input register then fills and stalls input.
// Reset (rst_n low, asynchronous) empties both stages; payload registers are not reset.
`default_nettype none

module x86_integer_alu_flags_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [3:0]  command,
    input  wire logic [1:0]  operand_size,
    input  wire logic [31:0] dest_value,
    input  wire logic [31:0] source_value,
    input  wire logic        sign_extend_byte,
    input  wire logic        carry_in,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [31:0] result,
    output      logic        write_back,
    output      logic        carry_flag,
    output      logic        parity_flag,
    output      logic        aux_carry_flag,
    output      logic        zero_flag,
    output      logic        sign_flag,
    output      logic        overflow_flag
);
    import xalu_pkg::*;

    logic      op_valid_reg;
    logic      op_valid_next;
    xalu_op_t  op_reg;
    logic      res_valid_reg;
    logic      res_valid_next;
    xalu_res_t res_reg;
    xalu_res_t res_comb;
    logic      res_open;
    logic      in_take;

    xalu_core u_core (
        .op  (op_reg),
        .res (res_comb)
    );

    assign res_open = ~res_valid_reg | out_ready;
    assign in_ready = ~op_valid_reg | res_open;
    assign in_take  = in_valid & in_ready;

    always_comb
    begin
        op_valid_next  = op_valid_reg;
        res_valid_next = res_valid_reg;
        if (res_open)
        begin
            res_valid_next = op_valid_reg;
            op_valid_next  = 1'b0;
        end
        if (in_take)
        begin
            op_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= '{command:          command,
                        operand_size:     operand_size,
                        dest_value:       dest_value,
                        source_value:     source_value,
                        sign_extend_byte: sign_extend_byte,
                        carry_in:         carry_in};
        end
        if (res_open && op_valid_reg)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid      = res_valid_reg;
    assign result         = res_reg.result;
    assign write_back     = res_reg.write_back;
    assign carry_flag     = res_reg.carry_flag;
    assign parity_flag    = res_reg.parity_flag;
    assign aux_carry_flag = res_reg.aux_carry_flag;
    assign zero_flag      = res_reg.zero_flag;
    assign sign_flag      = res_reg.sign_flag;
    assign overflow_flag  = res_reg.overflow_flag;

endmodule

`default_nettype wire

[sv/xalu_core.sv]
// Combinational datapath: operand masking, adder, logic ops and flag generation.
`default_nettype none

module xalu_core (
    input  xalu_pkg::xalu_op_t  op,
    output xalu_pkg::xalu_res_t res
);
    import xalu_pkg::*;

    logic [31:0] mask;
    logic [31:0] src_sel;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin_add;
    logic        cin_sub;
    logic [32:0] sum;
    logic [32:0] diff;
    logic [31:0] value;
    logic        known;

    function automatic logic msb_bit(input logic [31:0] v, input logic [1:0] size);
        logic bit_sel;
        unique case (size)
            SIZE_8:  bit_sel = v[7];
            SIZE_16: bit_sel = v[15];
            default: bit_sel = v[31];
        endcase
        return bit_sel;
    endfunction

    function automatic logic carry_bit(input logic [32:0] v, input logic [1:0] size);
        logic bit_sel;
        unique case (size)
            SIZE_8:  bit_sel = v[8];
            SIZE_16: bit_sel = v[16];
            default: bit_sel = v[32];
        endcase
        return bit_sel;
    endfunction

    always_comb
    begin
        unique case (op.operand_size)
            SIZE_8:  mask = 32'h0000_00FF;
            SIZE_16: mask = 32'h0000_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
    end

    assign src_sel = op.sign_extend_byte ? {{24{op.source_value[7]}}, op.source_value[7:0]}
                                         : op.source_value;
    assign a       = op.dest_value & mask;
    assign b       = src_sel & mask;
    assign cin_add = (op.command == CMD_ADC) & op.carry_in;
    assign cin_sub = (op.command == CMD_SBB) & op.carry_in;
    assign sum     = {1'b0, a} + {1'b0, b} + {32'd0, cin_add};
    assign diff    = {1'b0, a} - {1'b0, b} - {32'd0, cin_sub};

    always_comb
    begin
        value              = 32'd0;
        known              = 1'b1;
        res.write_back     = 1'b0;
        res.carry_flag     = 1'b0;
        res.aux_carry_flag = 1'b0;
        res.overflow_flag  = 1'b0;
        case (op.command) inside
            CMD_ADC, CMD_ADD:
            begin
                value              = sum[31:0] & mask;
                res.write_back     = 1'b1;
                res.carry_flag     = carry_bit(sum, op.operand_size);
                res.aux_carry_flag = a[4] ^ b[4] ^ value[4];
                res.overflow_flag  = msb_bit(~(a ^ b) & (a ^ value), op.operand_size);
            end
            CMD_CMP, CMD_SBB, CMD_SUB:
            begin
                value              = diff[31:0] & mask;
                res.write_back     = (op.command != CMD_CMP);
                res.carry_flag     = carry_bit(diff, op.operand_size);
                res.aux_carry_flag = a[4] ^ b[4] ^ value[4];
                res.overflow_flag  = msb_bit((a ^ b) & (a ^ value), op.operand_size);
            end
            CMD_AND, CMD_TEST:
            begin
                value          = a & b;
                res.write_back = (op.command != CMD_TEST);
            end
            CMD_OR:
            begin
                value          = a | b;
                res.write_back = 1'b1;
            end
            CMD_XOR:
            begin
                value          = a ^ b;
                res.write_back = 1'b1;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign res.result      = value;
    assign res.parity_flag = known & ~(^value[7:0]);
    assign res.zero_flag   = known & (value == 32'd0);
    assign res.sign_flag   = known & msb_bit(value, op.operand_size);

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// Testbench for x86_integer_alu_flags_unit: directed table, random items, self-checking flags.
`timescale 1ns / 100ps

module tb_top;
    import xalu_pkg::*;

    localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [1:0] SIZE_RSVD     = 2'd3;
    localparam int         RANDOM_PER_PHASE = 500;
    localparam int         HOLD_OFF_AT      = 1200;
    localparam int         HOLD_OFF_CYCLES  = 250;
    localparam int         DRAIN_CYCLES     = 10;

    typedef struct packed {
        xalu_op_t  op;
        logic      lit;
        xalu_res_t flags;
    } directed_row_t;

    localparam xalu_res_t NO_LIT = '0;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [3:0]  command;
    logic [1:0]  operand_size;
    logic [31:0] dest_value;
    logic [31:0] source_value;
    logic        sign_extend_byte;
    logic        carry_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] result;
    logic        write_back;
    logic        carry_flag;
    logic        parity_flag;
    logic        aux_carry_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic        overflow_flag;

    logic        cur_lit;
    xalu_res_t   cur_flags;
    xalu_res_t   alu_outcome_q [$];
    int          n_accepted;
    int          n_fail;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic        hold_off;

    directed_row_t directed_rows [24] = '{
        '{'{CMD_ADD,  SIZE_8,  32'h0000_00FF, 32'h0000_0001, 1'b0, 1'b0}, 1'b1,
          '{32'h0000_0000, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_ADD,  SIZE_32, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 1'b0}, 1'b1,
          '{32'h8000_0000, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1}},
        '{'{CMD_SUB,  SIZE_16, 32'h0000_0000, 32'h0000_0001, 1'b0, 1'b0}, 1'b1,
          '{32'h0000_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0}},
        '{'{CMD_SUB,  SIZE_8,  32'h0000_0080, 32'h0000_0001, 1'b0, 1'b0}, 1'b1,
          '{32'h0000_007F, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
        '{'{CMD_AND,  SIZE_32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
        '{'{CMD_TEST, SIZE_8,  32'h0000_0055, 32'h0000_00AA, 1'b0, 1'b0}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_CMP,  SIZE_32, 32'h1234_5678, 32'h1234_5678, 1'b0, 1'b0}, 1'b1,
          '{32'h0000_0000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0}},
        '{'{CMD_UNUSED_LO, SIZE_32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, NO_LIT},
        '{'{CMD_UNUSED_HI, SIZE_8,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b1, NO_LIT},
        '{'{CMD_ADC,  SIZE_32, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_ADC,  SIZE_8,  32'h0000_007F, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_SBB,  SIZE_16, 32'h0000_0000, 32'h0000_FFFF, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_SBB,  SIZE_32, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_OR,   SIZE_16, 32'h0000_8000, 32'h0000_0001, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_XOR,  SIZE_8,  32'h0000_00AA, 32'h0000_0055, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_ADD,  SIZE_16, 32'h0000_1234, 32'h0000_0080, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_SUB,  SIZE_32, 32'h0000_0000, 32'h0000_007F, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_ADD,  SIZE_8,  32'h0000_0010, 32'hFFFF_FF80, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_ADD,  SIZE_RSVD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_CMP,  SIZE_8,  32'hFFFF_FF00, 32'h0000_0001, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_XOR,  SIZE_32, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_OR,   SIZE_8,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{CMD_ADC,  SIZE_16, 32'h0000_FFFF, 32'h0000_FFFF, 1'b0, 1'b1}, 1'b0, NO_LIT},
        '{'{CMD_SBB,  SIZE_8,  32'h0000_0080, 32'h0000_007F, 1'b0, 1'b1}, 1'b0, NO_LIT}
    };

    x86_integer_alu_flags_unit u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .operand_size     (operand_size),
        .dest_value       (dest_value),
        .source_value     (source_value),
        .sign_extend_byte (sign_extend_byte),
        .carry_in         (carry_in),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .result           (result),
        .write_back       (write_back),
        .carry_flag       (carry_flag),
        .parity_flag      (parity_flag),
        .aux_carry_flag   (aux_carry_flag),
        .zero_flag        (zero_flag),
        .sign_flag        (sign_flag),
        .overflow_flag    (overflow_flag)
    );

    function automatic xalu_res_t compute_eflags(xalu_op_t op);
        xalu_res_t   r;
        int          w;
        logic [31:0] mask;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ov;
        logic [31:0] half;
        logic [32:0] wide;
        logic        c;
        r = '0;
        case (op.operand_size)
            SIZE_8:  w = 8;
            SIZE_16: w = 16;
            default: w = 32;
        endcase
        mask = (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
        a = op.dest_value & mask;
        b = op.sign_extend_byte ? {{24{op.source_value[7]}}, op.source_value[7:0]}
                                : op.source_value;
        b = b & mask;
        case (op.command)
            CMD_ADC, CMD_ADD:
            begin
                c = (op.command == CMD_ADC) && op.carry_in;
                wide = {1'b0, a} + {1'b0, b} + 33'(c);
                r.result = wide[31:0] & mask;
                r.carry_flag = wide[w];
                ov = ~(a ^ b) & (a ^ r.result);
                r.overflow_flag = ov[w-1];
                half = a ^ b ^ r.result;
                r.aux_carry_flag = half[4];
                r.write_back = 1'b1;
            end
            CMD_CMP, CMD_SBB, CMD_SUB:
            begin
                c = (op.command == CMD_SBB) && op.carry_in;
                wide = {1'b0, a} - {1'b0, b} - 33'(c);
                r.result = wide[31:0] & mask;
                r.carry_flag = ({1'b0, a} < ({1'b0, b} + 33'(c)));
                ov = (a ^ b) & (a ^ r.result);
                r.overflow_flag = ov[w-1];
                half = a ^ b ^ r.result;
                r.aux_carry_flag = half[4];
                r.write_back = (op.command != CMD_CMP);
            end
            CMD_AND, CMD_TEST:
            begin
                r.result = a & b;
                r.write_back = (op.command != CMD_TEST);
            end
            CMD_OR:
            begin
                r.result = a | b;
                r.write_back = 1'b1;
            end
            CMD_XOR:
            begin
                r.result = a ^ b;
                r.write_back = 1'b1;
            end
            default:
            begin
                return '0;
            end
        endcase
        r.parity_flag = ~^r.result[7:0];
        r.zero_flag = (r.result == 32'h0);
        r.sign_flag = r.result[w-1];
        return r;
    endfunction

    function automatic logic [31:0] pick_operand();
        logic [31:0] corners [8];
        corners = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_007F, 32'h0000_0080,
                    32'h0000_7FFF, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000};
        if ($urandom_range(9) < 4)
            return corners[$urandom_range(7)];
        return $urandom();
    endfunction

    function automatic xalu_op_t random_op();
        xalu_op_t op;
        if ($urandom_range(19) == 0)
            op.command = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        else
            op.command = 4'($urandom_range(CMD_XOR, CMD_ADC));
        if ($urandom_range(19) == 0)
            op.operand_size = SIZE_RSVD;
        else
            op.operand_size = 2'($urandom_range(SIZE_32, SIZE_8));
        op.dest_value = pick_operand();
        op.source_value = ($urandom_range(9) == 0) ? op.dest_value : pick_operand();
        op.sign_extend_byte = 1'($urandom_range(1));
        op.carry_in = 1'($urandom_range(1));
        return op;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            n_fail++;
        end
    endtask

    task automatic send_op(input xalu_op_t op, input logic lit, input xalu_res_t flags);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        command          <= op.command;
        operand_size     <= op.operand_size;
        dest_value       <= op.dest_value;
        source_value     <= op.source_value;
        sign_extend_byte <= op.sign_extend_byte;
        carry_in         <= op.carry_in;
        cur_lit          <= lit;
        cur_flags        <= flags;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** x86_integer_alu_flags_unit: FAILED **");
        $finish;
    end

    // receiver side
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // hold off the receiver while items keep coming
    initial
    begin
        hold_off = 1'b0;
        wait (n_accepted == HOLD_OFF_AT);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin : scoreboard
        xalu_op_t  op;
        xalu_res_t got;
        xalu_res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{result, write_back, carry_flag, parity_flag, aux_carry_flag,
                        zero_flag, sign_flag, overflow_flag};
                if (alu_outcome_q.size() == 0)
                begin
                    $error("result %h with no item outstanding", got.result);
                    n_fail++;
                end
                else
                begin
                    want = alu_outcome_q.pop_front();
                    check_field("result", want.result, got.result);
                    check_field("write_back", 32'(want.write_back), 32'(got.write_back));
                    check_field("carry_flag", 32'(want.carry_flag), 32'(got.carry_flag));
                    check_field("parity_flag", 32'(want.parity_flag), 32'(got.parity_flag));
                    check_field("aux_carry_flag", 32'(want.aux_carry_flag),
                                32'(got.aux_carry_flag));
                    check_field("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
                    check_field("sign_flag", 32'(want.sign_flag), 32'(got.sign_flag));
                    check_field("overflow_flag", 32'(want.overflow_flag),
                                32'(got.overflow_flag));
                end
            end
            if (in_valid && in_ready)
            begin
                op = '{command, operand_size, dest_value, source_value,
                       sign_extend_byte, carry_in};
                alu_outcome_q.push_back(cur_lit ? cur_flags : compute_eflags(op));
                n_accepted++;
            end
        end
    end

    initial
    begin
        in_valid         = 1'b0;
        command          = CMD_ADD;
        operand_size     = SIZE_8;
        dest_value       = '0;
        source_value     = '0;
        sign_extend_byte = 1'b0;
        carry_in         = 1'b0;
        cur_lit          = 1'b0;
        cur_flags        = '0;
        n_accepted       = 0;
        n_fail           = 0;
        send_idle_pct    = 6;
        recv_stall_pct   = 75;
        rst_n            = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].lit, directed_rows[i].flags);

        repeat (RANDOM_PER_PHASE) send_op(random_op(), 1'b0, NO_LIT);
        send_idle_pct  = 75;
        recv_stall_pct = 6;
        repeat (RANDOM_PER_PHASE) send_op(random_op(), 1'b0, NO_LIT);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (RANDOM_PER_PHASE) send_op(random_op(), 1'b0, NO_LIT);

        @(negedge clk);
        in_valid <= 1'b0;
        while (alu_outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (n_fail == 0)
            $display("** x86_integer_alu_flags_unit: PASSED **");
        else
            $display("** x86_integer_alu_flags_unit: FAILED **");
        $finish;
    end

endmodule
